/* src/ols_pkg.sv */
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and codes for the ordered list store: command and result
// words, op and error codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ols_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_READ   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_RANGE = 2'd3
  } err_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  index;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] data;
    logic [3:0]  position;
    logic        found;
    logic [4:0]  count;
    logic        vacant;
    err_t        error;
  } res_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic step;    // queue step: pop the head, shift the row down one
    logic keep;    // popped head goes back in at the tail
    logic append;  // write the load word just past the tail
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/ordered_list_store_unit.sv */
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// Fixed-capacity ordered list held in a row of word cells. The occupied
// cells form a queue whose head is cell 0; insert, delete, remove, find and
// read rotate the list once through the head, one word a cycle bar an append.
// ----------------------------------------------------------------------------
//  channel   signals               direction   handshake
//  command   start, cmd, busy      in          taken when start && !busy
//  result    done, result          out         one cycle per strobe, no stall
//
//  push, pop, the unused op code, any error, and remove or find on an empty
//  list: busy stays low, done is high in the cycle after start.
//  delete, remove, find, read, insert: busy while the row rotates one word
//  per cycle through cell 0, held for the append on insert, then the result
//  is posted, with done high in the same cycle that busy falls.
//  rst (synchronous) empties the list; cell contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_store_unit #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire ols_pkg::cmd_t   cmd,
  output logic                 busy,
  output logic                 done,
  output ols_pkg::res_t        result
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int IDX_BITS = (CNT_BITS > 4) ? CNT_BITS : 4;

  ols_pkg::state_t         state, state_next;
  logic [CNT_BITS-1:0]     count, count_next;
  logic [CNT_BITS-1:0]     n_orig;
  logic [CNT_BITS-1:0]     k, k_next;
  logic [2:0]              op_r;
  logic [3:0]              idx_r;
  logic [WORD_BITS-1:0]    val_r;
  logic                    ins_done, ins_next;
  logic                    found_r, found_next;
  logic [3:0]              pos_r, pos_next;
  logic [31:0]             data_r, data_next;
  logic                    done_next;
  ols_pkg::res_t           result_next;

  ols_pkg::cell_ctl_t      ctl;
  logic [WORD_BITS-1:0]    load_word;
  logic [WORD_BITS-1:0]    vin;
  logic [WORD_BITS-1:0]    word_q [DEPTH];
  logic [WORD_BITS-1:0]    head;
  logic                    accept, go_run, finish, list_full, list_empty;
  logic [IDX_BITS-1:0]     idx_in, idx_run, cnt_ext, k_ext;
  ols_pkg::err_t           err;

  assign busy       = (state != ols_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign vin        = WORD_BITS'(cmd.value);
  assign head       = word_q[0];
  assign list_full  = (count == CNT_BITS'(DEPTH));
  assign list_empty = (count == '0);
  assign idx_in     = IDX_BITS'(cmd.index);
  assign idx_run    = IDX_BITS'(idx_r);
  assign cnt_ext    = IDX_BITS'(count);
  assign k_ext      = IDX_BITS'(k);

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] right_word;
    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid
      assign right_word = word_q[i+1];
    end
    ols_cell #(
      .WORD_BITS  (WORD_BITS),
      .CNT_BITS   (CNT_BITS),
      .CELL_INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .len        (count),
      .right_word (right_word),
      .head_word  (head),
      .load_word  (load_word),
      .word       (word_q[i])
    );
  end

  // ------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ols_pkg::ST_IDLE: begin
        if (go_run) state_next = ols_pkg::ST_RUN;
      end
      ols_pkg::ST_RUN: begin
        if (finish) state_next = ols_pkg::ST_IDLE;
      end
      default: state_next = ols_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    ctl         = '0;
    load_word   = val_r;
    count_next  = count;
    k_next      = k;
    ins_next    = ins_done;
    found_next  = found_r;
    pos_next    = pos_r;
    data_next   = data_r;
    done_next   = 1'b0;
    result_next = result;
    go_run      = 1'b0;
    finish      = 1'b0;
    err         = ols_pkg::ERR_OK;

    case (state)
      ols_pkg::ST_IDLE: begin
        if (accept) begin
          load_word = vin;
          case (cmd.op)
            ols_pkg::OP_PUSH: begin
              if (list_full) begin
                err = ols_pkg::ERR_FULL;
              end else begin
                ctl.append = 1'b1;
                count_next = count + CNT_BITS'(1);
              end
            end
            ols_pkg::OP_POP: begin
              if (list_empty) err = ols_pkg::ERR_EMPTY;
              else count_next = count - CNT_BITS'(1);
            end
            ols_pkg::OP_INSERT: begin
              if (list_full) err = ols_pkg::ERR_FULL;
              else if (idx_in > cnt_ext) err = ols_pkg::ERR_RANGE;
              else go_run = 1'b1;
            end
            ols_pkg::OP_DELETE, ols_pkg::OP_READ: begin
              if (list_empty) err = ols_pkg::ERR_EMPTY;
              else if (idx_in >= cnt_ext) err = ols_pkg::ERR_RANGE;
              else go_run = 1'b1;
            end
            ols_pkg::OP_REMOVE, ols_pkg::OP_FIND: begin
              if (!list_empty) go_run = 1'b1;
            end
            default: ;
          endcase

          if (go_run) begin
            k_next     = '0;
            ins_next   = 1'b0;
            found_next = 1'b0;
            pos_next   = '0;
            data_next  = '0;
          end else begin
            done_next            = 1'b1;
            result_next.data     = '0;
            result_next.position = '0;
            result_next.found    = 1'b0;
            result_next.count    = 5'(count_next);
            result_next.vacant   = (count_next == '0);
            result_next.error    = err;
          end
        end
      end

      ols_pkg::ST_RUN: begin
        if ((k == n_orig) && ((op_r != ols_pkg::OP_INSERT) || ins_done)) begin
          finish               = 1'b1;
          done_next            = 1'b1;
          result_next.data     = data_r;
          result_next.position = pos_r;
          result_next.found    = found_r;
          result_next.count    = 5'(count);
          result_next.vacant   = list_empty;
          result_next.error    = ols_pkg::ERR_OK;
        end else begin
          case (op_r)
            ols_pkg::OP_INSERT: begin
              if (!ins_done && (k_ext == idx_run)) begin
                ctl.append = 1'b1;
                count_next = count + CNT_BITS'(1);
                ins_next   = 1'b1;
              end else begin
                ctl.step = 1'b1;
                ctl.keep = 1'b1;
                k_next   = k + CNT_BITS'(1);
              end
            end
            ols_pkg::OP_DELETE: begin
              ctl.step = 1'b1;
              ctl.keep = (k_ext != idx_run);
              k_next   = k + CNT_BITS'(1);
              if (k_ext == idx_run) count_next = count - CNT_BITS'(1);
            end
            ols_pkg::OP_REMOVE: begin
              ctl.step = 1'b1;
              ctl.keep = (head != val_r);
              k_next   = k + CNT_BITS'(1);
              if (head == val_r) count_next = count - CNT_BITS'(1);
            end
            ols_pkg::OP_FIND: begin
              ctl.step = 1'b1;
              ctl.keep = 1'b1;
              k_next   = k + CNT_BITS'(1);
              if (!found_r && (head == val_r)) begin
                found_next = 1'b1;
                pos_next   = 4'(k);
              end
            end
            ols_pkg::OP_READ: begin
              ctl.step = 1'b1;
              ctl.keep = 1'b1;
              k_next   = k + CNT_BITS'(1);
              if (k_ext == idx_run) data_next = 32'(head);
            end
            default: ;
          endcase
        end
      end

      default: ;
    endcase
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ols_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    k        <= k_next;
    ins_done <= ins_next;
    found_r  <= found_next;
    pos_r    <= pos_next;
    data_r   <= data_next;
    result   <= result_next;
    if (go_run) begin
      op_r   <= cmd.op;
      idx_r  <= cmd.index;
      val_r  <= vin;
      n_orig <= count;
    end
  end

  // ------------------------------------------------------------- assertions
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("fill count above capacity");

  a_quick_reply: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted word neither answered nor in progress");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    (done && (result.error != ols_pkg::ERR_OK)) |-> $stable(count))
    else $error("store changed on an error");

  a_rotate_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ols_pkg::ST_RUN) |-> (k <= n_orig))
    else $error("rotation step past list length");

endmodule

`default_nettype wire

/* src/ols_cell.sv */
// ----------------------------------------------------------------------------
// ols_cell
// One word of the list row. Takes its right neighbor on a queue step, the
// head word when it is the tail and the head is kept, or the load word
// when it sits just past the tail during an append.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ols_cell #(
  parameter int WORD_BITS  = 32,
  parameter int CNT_BITS   = 5,
  parameter int CELL_INDEX = 0
) (
  input  wire logic                  clk,
  input  wire ols_pkg::cell_ctl_t    ctl,
  input  wire logic [CNT_BITS-1:0]   len,
  input  wire logic [WORD_BITS-1:0]  right_word,
  input  wire logic [WORD_BITS-1:0]  head_word,
  input  wire logic [WORD_BITS-1:0]  load_word,
  output logic      [WORD_BITS-1:0]  word
);

  localparam logic [CNT_BITS-1:0] POS    = CNT_BITS'(CELL_INDEX);
  localparam logic [CNT_BITS-1:0] POS_UP = CNT_BITS'(CELL_INDEX + 1);

  always_ff @(posedge clk) begin
    if (ctl.append && (len == POS)) begin
      word <= load_word;
    end else if (ctl.step) begin
      if (POS_UP < len) begin
        word <= right_word;
      end else if ((POS_UP == len) && ctl.keep) begin
        word <= head_word;
      end
    end
  end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ordered_list_store_unit. Words are sent through
// the start/busy handshake while a shadow copy of the list predicts each
// result. Each done strobe is compared field by field with the oldest
// prediction. Directed cases on an empty, partly filled and full list come
// first. Random traffic follows in three phases of differing sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_CAP = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  ols_pkg::cmd_t cmd = '0;
  logic busy;
  logic done;
  ols_pkg::res_t result;

  logic [31:0] list_words [LIST_CAP];
  int list_len = 0;
  int fill_goal = 0;
  ols_pkg::res_t expected_results [$];
  ols_pkg::res_t oldest_result;
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int cycle_count = 0;

  ordered_list_store_unit #(
    .DEPTH(LIST_CAP),
    .WORD_BITS(32)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // shadow list update, returns the result the word should produce
  function automatic ols_pkg::res_t apply_list_op(ols_pkg::cmd_t word);
    ols_pkg::res_t r;
    int i;
    int w;
    r = '0;
    r.error = ols_pkg::ERR_OK;
    case (word.op)
      ols_pkg::OP_PUSH: begin
        if (list_len >= LIST_CAP) begin
          r.error = ols_pkg::ERR_FULL;
        end else begin
          list_words[list_len] = word.value;
          list_len++;
        end
      end
      ols_pkg::OP_POP: begin
        if (list_len == 0) r.error = ols_pkg::ERR_EMPTY;
        else list_len--;
      end
      ols_pkg::OP_INSERT: begin
        if (list_len >= LIST_CAP) begin
          r.error = ols_pkg::ERR_FULL;
        end else if (int'(word.index) > list_len) begin
          r.error = ols_pkg::ERR_RANGE;
        end else begin
          for (i = list_len; i > int'(word.index); i--) list_words[i] = list_words[i - 1];
          list_words[word.index] = word.value;
          list_len++;
        end
      end
      ols_pkg::OP_DELETE: begin
        if (list_len == 0) begin
          r.error = ols_pkg::ERR_EMPTY;
        end else if (int'(word.index) >= list_len) begin
          r.error = ols_pkg::ERR_RANGE;
        end else begin
          for (i = int'(word.index); i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      ols_pkg::OP_REMOVE: begin
        w = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] != word.value) begin
            list_words[w] = list_words[i];
            w++;
          end
        end
        list_len = w;
      end
      ols_pkg::OP_FIND: begin
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == word.value) begin
            r.found = 1'b1;
            r.position = i[3:0];
          end
        end
      end
      ols_pkg::OP_READ: begin
        if (list_len == 0) r.error = ols_pkg::ERR_EMPTY;
        else if (int'(word.index) >= list_len) r.error = ols_pkg::ERR_RANGE;
        else r.data = list_words[word.index];
      end
      default: begin
      end
    endcase
    r.count = list_len[4:0];
    r.vacant = (list_len == 0);
    return r;
  endfunction

  task automatic send_word(logic [2:0] op, logic [3:0] index, logic [31:0] value);
    int gap;
    ols_pkg::cmd_t word;
    gap = 0;
    word.op = op;
    word.index = index;
    word.value = value;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= word;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_list_op(word));
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result expected none got %h", $time, result);
      end else begin
        oldest_result = expected_results.pop_front();
        compare_field("data", oldest_result.data, result.data);
        compare_field("position", oldest_result.position, result.position);
        compare_field("found", oldest_result.found, result.found);
        compare_field("count", oldest_result.count, result.count);
        compare_field("vacant", oldest_result.vacant, result.vacant);
        compare_field("error", oldest_result.error, result.error);
      end
    end
  end

  task automatic test_empty_list();
    send_word(ols_pkg::OP_POP, 4'd0, 32'd0);
    send_word(ols_pkg::OP_DELETE, 4'd0, 32'd0);
    send_word(ols_pkg::OP_READ, 4'd15, 32'd0);
    send_word(ols_pkg::OP_INSERT, 4'd1, 32'h1234_5678);
    send_word(ols_pkg::OP_FIND, 4'd0, 32'd0);
    send_word(ols_pkg::OP_REMOVE, 4'd0, 32'd0);
    send_word(OP_UNUSED, 4'd15, 32'hffff_ffff);
  endtask

  task automatic test_shift_edits();
    send_word(ols_pkg::OP_INSERT, 4'd0, 32'hffff_ffff);
    send_word(ols_pkg::OP_PUSH, 4'd0, 32'd0);
    send_word(ols_pkg::OP_INSERT, 4'd2, 32'd5);     // index equal to count appends
    send_word(ols_pkg::OP_INSERT, 4'd1, 32'd5);
    send_word(ols_pkg::OP_READ, 4'd3, 32'd0);
    send_word(ols_pkg::OP_FIND, 4'd0, 32'd5);
    send_word(ols_pkg::OP_FIND, 4'd0, 32'd7);
    send_word(ols_pkg::OP_DELETE, 4'd0, 32'd0);
    send_word(ols_pkg::OP_REMOVE, 4'd0, 32'd5);     // drops both copies
    send_word(ols_pkg::OP_READ, 4'd1, 32'd0);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_CAP) send_word(ols_pkg::OP_PUSH, 4'd0, $urandom());
    send_word(ols_pkg::OP_PUSH, 4'd0, 32'd9);
    send_word(ols_pkg::OP_INSERT, 4'd15, 32'd9);    // full refuses even an in-range index
    send_word(ols_pkg::OP_READ, 4'd15, 32'd0);
    send_word(ols_pkg::OP_DELETE, 4'd15, 32'd0);
    send_word(ols_pkg::OP_READ, 4'd15, 32'd0);
  endtask

  // fill level wanders toward a random goal so both ends get exercised
  task automatic test_random_traffic(int words);
    int r;
    int hi;
    logic [2:0] op;
    logic [3:0] idx;
    logic [31:0] val;
    repeat (words) begin
      if (list_len == fill_goal) fill_goal = $urandom_range(0, LIST_CAP);
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (r < 15) op = ols_pkg::OP_FIND;
      else if (r < 27) op = ols_pkg::OP_READ;
      else if (r < 32) op = (r % 2) ? ols_pkg::OP_PUSH : ols_pkg::OP_INSERT;
      else if (r < 36) op = (r % 2) ? ols_pkg::OP_POP : ols_pkg::OP_DELETE;
      else if (list_len < fill_goal) op = (r < 75) ? ols_pkg::OP_PUSH : ols_pkg::OP_INSERT;
      else if (r < 60) op = ols_pkg::OP_POP;
      else if (r < 85) op = ols_pkg::OP_DELETE;
      else op = ols_pkg::OP_REMOVE;
      if ($urandom_range(0, 9) == 0) begin
        idx = 4'($urandom_range(0, 15));
      end else begin
        hi = (op == ols_pkg::OP_INSERT) ? list_len : list_len - 1;
        if (hi < 0) hi = 0;
        if (hi > 15) hi = 15;
        idx = 4'($urandom_range(0, hi));
      end
      r = $urandom_range(0, 99);
      if (r < 35 && list_len > 0) val = list_words[4'($urandom_range(0, list_len - 1))];
      else if (r < 45) val = (r % 2) ? 32'hffff_ffff : 32'd0;
      else if (r < 70) val = $urandom_range(0, 3);
      else val = $urandom();
      send_word(op, idx, val);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_shift_edits();
    test_full_list();
    sender_idle_pct = 20;
    test_random_traffic(460);
    sender_idle_pct = 82;
    test_random_traffic(460);
    sender_idle_pct = 0;
    test_random_traffic(460);
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
